// ----- hdl/adaptive_freq_interval_model_core_macros.svh -----
// assertion macros for the adaptive frequency interval model
// used by the rtl files that carry concurrent checks; no other dependencies
`ifndef ADAPTIVE_FREQ_INTERVAL_MODEL_CORE_MACROS_SVH
`define ADAPTIVE_FREQ_INTERVAL_MODEL_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define AFIM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// consequence must hold in the cycle after the trigger
`define AFIM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define AFIM_ASSERT(lbl, clk, rst_n, prop, msg)
`define AFIM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- hdl/afim_pkg.sv -----
// shared widths, mode and register codes and divider request and response types
// no dependencies
package afim_pkg;
	localparam int unsigned MODE_W    = 2;
	localparam int unsigned SYM_W     = 8;
	localparam int unsigned CNT_W     = 24;
	localparam int unsigned VAL_W     = 32;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned PROD_W    = CNT_W + VAL_W;

	localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_NORM  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_INIT  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_QUERY = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_LOW  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH = 1'b1;

	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] dividend;
		logic [VAL_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [VAL_W-1:0] quotient;
	} div_rsp_t;
endpackage

// ----- hdl/afim_if.sv -----
// request channel interfaces: input items, results and register writes
// depends on afim_pkg
interface afim_in_if;
	logic                           valid;
	logic                           ready;
	logic [afim_pkg::MODE_W-1:0]    mode;
	logic [afim_pkg::SYM_W-1:0]     symbol;
	logic [afim_pkg::CNT_W-1:0]     count;
	modport source (output valid, mode, symbol, count, input ready);
	modport sink (input valid, mode, symbol, count, output ready);
endinterface

interface afim_out_if;
	logic                        valid;
	logic                        ready;
	logic [afim_pkg::VAL_W-1:0]  range_low;
	logic [afim_pkg::VAL_W-1:0]  range_high;
	logic [afim_pkg::VAL_W-1:0]  total_count;
	logic [afim_pkg::SYM_W-1:0]  top_symbol;
	modport source (output valid, range_low, range_high, total_count, top_symbol,
		input ready);
	modport sink (input valid, range_low, range_high, total_count, top_symbol,
		output ready);
endinterface

interface afim_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [afim_pkg::CFG_IDX_W-1:0]  index;
	logic [afim_pkg::VAL_W-1:0]      data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/afim_ram.sv -----
// single write port, single read port synchronous ram, registered read data
// no dependencies
module afim_ram #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned WIDTH = 32,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ----- hdl/afim_div.sv -----
// restoring divider, one quotient bit per cycle, 56-bit dividend by 32-bit divisor
// depends on afim_pkg
module afim_div (
	input  logic               clk,
	input  logic               arst_n,
	input  afim_pkg::div_req_t req,
	output afim_pkg::div_rsp_t rsp
);
	localparam int unsigned PW     = afim_pkg::PROD_W;
	localparam int unsigned VW     = afim_pkg::VAL_W;
	localparam int unsigned STEP_W = $clog2(PW);

	logic [PW-1:0]     dvd_q;
	logic [VW-1:0]     dsr_q;
	logic [VW-1:0]     rem_q;
	logic [STEP_W-1:0] step_q;
	logic              run_q;
	logic              done_q;
	logic [VW:0]       trial;
	logic [VW:0]       diff;
	logic              fits;

	// one trial subtraction per step
	assign trial = {rem_q, dvd_q[PW-1]};
	assign fits  = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			dvd_q  <= '0;
			dsr_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				dvd_q  <= req.dividend;
				dsr_q  <= req.divisor;
				rem_q  <= '0;
				step_q <= '0;
				run_q  <= 1'b1;
			end else if (run_q) begin
				rem_q  <= fits ? diff[VW-1:0] : trial[VW-1:0];
				dvd_q  <= {dvd_q[PW-2:0], fits};
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(PW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q[VW-1:0];
endmodule

// ----- hdl/adaptive_freq_interval_model_core.sv -----
// Load: count read and write, then output; query: two bound reads, then output; one item at a time.
// Initialise and normalise walk every symbol through the shared divider (56 quotient
// bits per division), with a scan pass over every symbol first for normalise and
// a gap pass over the bounds above the top symbol when a gap is left.
// After reset the block runs an initialise pass with input ready low;
// register writes are taken at all times.
`include "adaptive_freq_interval_model_core_macros.svh"
module adaptive_freq_interval_model_core #(
	parameter int unsigned NUM_SYMBOLS = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	afim_in_if.sink      din,
	afim_out_if.source   dout,
	afim_cfg_if.sink     cfg
);
	localparam int unsigned N   = NUM_SYMBOLS;
	localparam int unsigned CAW = $clog2(N);
	localparam int unsigned IW  = $clog2(N + 1);
	localparam int unsigned CW  = afim_pkg::CNT_W;
	localparam int unsigned VW  = afim_pkg::VAL_W;
	localparam int unsigned SW  = afim_pkg::SYM_W;
	localparam int unsigned PW  = afim_pkg::PROD_W;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_LOAD_RD = 4'd1;
	localparam logic [3:0] ST_QRY1    = 4'd2;
	localparam logic [3:0] ST_QRY2    = 4'd3;
	localparam logic [3:0] ST_SCALE   = 4'd4;
	localparam logic [3:0] ST_REB_RD  = 4'd5;
	localparam logic [3:0] ST_REB_DIV = 4'd6;
	localparam logic [3:0] ST_GAP0    = 4'd7;
	localparam logic [3:0] ST_GAP     = 4'd8;
	localparam logic [3:0] ST_OUT     = 4'd9;

	logic [3:0]                  state_q;
	logic                        rst_pass_q;
	logic                        init_q;
	logic                        do_scale_q;
	logic [SW-1:0]               sym_q;
	logic [CW-1:0]               cnt_q;
	logic [IW-1:0]               idx_q;
	logic [VW-1:0]               total_q;
	logic [CAW-1:0]              top_q;
	logic [VW-1:0]               low_q;
	logic [VW-1:0]               high_q;
	logic [VW-1:0]               span_q;
	logic [VW-1:0]               acc_q;
	logic [VW-1:0]               gap_q;
	logic [VW-1:0]               sum_q;
	logic [CW-1:0]               max_q;
	logic [CAW-1:0]              maxidx_q;
	logic [CW-1:0]               ctop_q;
	logic [VW-1:0]               rlo_q;
	logic [VW-1:0]               rhi_q;
	logic                        out_valid_q;
	logic [VW-1:0]               out_lo_q;
	logic [VW-1:0]               out_hi_q;
	logic [VW-1:0]               out_total_q;
	logic [SW-1:0]               out_top_q;

	logic                        accept;
	logic                        sym_ok;
	logic                        last;
	logic                        gap_last;
	logic [CW-1:0]               nc;
	logic                        take;
	logic [CW-1:0]               max_n;
	logic [CAW-1:0]              maxidx_n;
	logic [CW-1:0]               ctop_n;
	logic [VW-1:0]               sum_n;
	logic [CW-1:0]               c_eff;
	logic                        commit;
	logic [VW-1:0]               part;
	logic [VW-1:0]               acc_next;
	logic [VW-1:0]               gap_next;
	logic                        rb_start;

	logic                        c_we;
	logic [CAW-1:0]              c_waddr;
	logic [CW-1:0]               c_wdata;
	logic [CAW-1:0]              c_raddr;
	logic [CW-1:0]               c_rdata;
	logic                        b_we;
	logic [IW-1:0]               b_waddr;
	logic [VW-1:0]               b_wdata;
	logic [IW-1:0]               b_raddr;
	logic [VW-1:0]               b_rdata;

	afim_pkg::div_req_t          div_req;
	afim_pkg::div_rsp_t          div_rsp;

	// count and bound stores
	afim_ram #(.DEPTH(N), .WIDTH(CW)) u_counts (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
		.raddr(c_raddr), .rdata(c_rdata)
	);

	afim_ram #(.DEPTH(N + 1), .WIDTH(VW)) u_bounds (
		.clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
		.raddr(b_raddr), .rdata(b_rdata)
	);

	afim_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	// handshakes
	assign din.ready = (state_q == ST_IDLE) && !rst_pass_q;
	assign cfg.ready = 1'b1;
	assign accept    = din.valid && din.ready;
	assign sym_ok    = 32'(din.symbol) < 32'(N);

	assign dout.valid       = out_valid_q;
	assign dout.range_low   = out_lo_q;
	assign dout.range_high  = out_hi_q;
	assign dout.total_count = out_total_q;
	assign dout.top_symbol  = out_top_q;

	// scan pass: scaled count, running sum and first maximum
	always_comb begin
		last     = idx_q == IW'(N - 1);
		gap_last = idx_q == IW'(N);
		nc       = do_scale_q ? CW'((25'(c_rdata) + 25'd7) >> 3) : c_rdata;
		take     = (idx_q == '0) || (nc > max_q);
		max_n    = take ? nc : max_q;
		maxidx_n = take ? idx_q[CAW-1:0] : maxidx_q;
		ctop_n   = (idx_q[CAW-1:0] == top_q) ? nc : ctop_q;
		sum_n    = ((idx_q == '0) ? '0 : sum_q) + VW'(nc);
	end

	// rebuild: product into the divider, bound accumulate
	always_comb begin
		c_eff            = init_q ? CW'(1) : c_rdata;
		div_req.start    = (state_q == ST_REB_RD) && (total_q != '0);
		div_req.dividend = PW'(span_q) * PW'(c_eff);
		div_req.divisor  = total_q;
		commit   = ((state_q == ST_REB_RD) && (total_q == '0)) ||
			((state_q == ST_REB_DIV) && div_rsp.done);
		part     = (state_q == ST_REB_DIV) ? div_rsp.quotient : '0;
		acc_next = acc_q + part;
		gap_next = high_q - acc_next;
		rb_start = ((state_q == ST_IDLE) &&
			(rst_pass_q || (accept && din.mode == afim_pkg::MODE_INIT))) ||
			((state_q == ST_SCALE) && last);
	end

	// memory port control
	always_comb begin
		c_we    = 1'b0;
		c_waddr = idx_q[CAW-1:0];
		c_wdata = nc;
		c_raddr = '0;
		b_we    = 1'b0;
		b_waddr = idx_q + IW'(1);
		b_wdata = acc_next;
		b_raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (!rst_pass_q && accept && sym_ok) begin
					if (din.mode == afim_pkg::MODE_LOAD) begin
						c_raddr = CAW'(din.symbol);
					end
					if (din.mode == afim_pkg::MODE_QUERY) begin
						b_raddr = IW'(din.symbol);
					end
				end
			end
			ST_LOAD_RD: begin
				c_we    = 1'b1;
				c_waddr = CAW'(sym_q);
				c_wdata = cnt_q;
			end
			ST_QRY1: begin
				b_raddr = IW'(sym_q) + IW'(1);
			end
			ST_SCALE: begin
				c_we = do_scale_q;
				if (!last) begin
					c_raddr = CAW'(idx_q + IW'(1));
				end
			end
			ST_REB_RD, ST_REB_DIV: begin
				if (state_q == ST_REB_RD && init_q) begin
					c_we    = 1'b1;
					c_wdata = CW'(1);
				end
				if (commit) begin
					b_we = 1'b1;
					if (!last) begin
						c_raddr = CAW'(idx_q + IW'(1));
					end
				end
			end
			ST_GAP0: begin
				b_raddr = idx_q;
			end
			ST_GAP: begin
				b_we    = 1'b1;
				b_waddr = idx_q;
				b_wdata = b_rdata + gap_q;
				if (!gap_last) begin
					b_raddr = idx_q + IW'(1);
				end
			end
			default: begin
			end
		endcase
		if (rb_start) begin
			b_we    = 1'b1;
			b_waddr = '0;
			b_wdata = low_q;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			high_q <= '1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				afim_pkg::REG_LOW:  low_q  <= cfg.data;
				afim_pkg::REG_HIGH: high_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rst_pass_q  <= 1'b1;
			init_q      <= 1'b0;
			do_scale_q  <= 1'b0;
			sym_q       <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			total_q     <= VW'(N);
			top_q       <= CAW'(N - 1);
			span_q      <= '0;
			acc_q       <= '0;
			gap_q       <= '0;
			sum_q       <= '0;
			max_q       <= '0;
			maxidx_q    <= '0;
			ctop_q      <= '0;
			rlo_q       <= '0;
			rhi_q       <= '0;
			out_valid_q <= 1'b0;
			out_lo_q    <= '0;
			out_hi_q    <= '0;
			out_total_q <= '0;
			out_top_q   <= '0;
		end else begin
			if (dout.ready && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (rst_pass_q) begin
						init_q  <= 1'b1;
						total_q <= VW'(N);
						top_q   <= CAW'(N - 1);
					end else if (accept) begin
						sym_q  <= din.symbol;
						cnt_q  <= din.count;
						rlo_q  <= '0;
						rhi_q  <= '0;
						init_q <= (din.mode == afim_pkg::MODE_INIT);
						unique case (din.mode)
							afim_pkg::MODE_LOAD:  state_q <= sym_ok ? ST_LOAD_RD : ST_OUT;
							afim_pkg::MODE_QUERY: state_q <= sym_ok ? ST_QRY1 : ST_OUT;
							afim_pkg::MODE_NORM: begin
								do_scale_q <= total_q > (high_q >> 2);
								idx_q      <= '0;
								state_q    <= ST_SCALE;
							end
							afim_pkg::MODE_INIT: begin
								total_q <= VW'(N);
								top_q   <= CAW'(N - 1);
							end
							default: begin
							end
						endcase
					end
				end
				ST_LOAD_RD: begin
					total_q <= total_q - VW'(c_rdata) + VW'(cnt_q);
					state_q <= ST_OUT;
				end
				ST_QRY1: begin
					rlo_q   <= b_rdata;
					state_q <= ST_QRY2;
				end
				ST_QRY2: begin
					rhi_q   <= b_rdata;
					state_q <= ST_OUT;
				end
				ST_SCALE: begin
					sum_q    <= sum_n;
					max_q    <= max_n;
					maxidx_q <= maxidx_n;
					ctop_q   <= ctop_n;
					if (!last) begin
						idx_q <= idx_q + IW'(1);
					end else begin
						top_q <= (max_n > ctop_n) ? maxidx_n : top_q;
						if (do_scale_q) begin
							total_q <= sum_n;
						end
					end
				end
				ST_REB_RD: begin
					if (total_q != '0) begin
						state_q <= ST_REB_DIV;
					end
				end
				ST_REB_DIV: begin
				end
				ST_GAP0: begin
					state_q <= ST_GAP;
				end
				ST_GAP: begin
					idx_q <= idx_q + IW'(1);
					if (gap_last) begin
						if (rst_pass_q) begin
							rst_pass_q <= 1'b0;
							state_q    <= ST_IDLE;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (!out_valid_q || dout.ready) begin
						out_valid_q <= 1'b1;
						out_lo_q    <= rlo_q;
						out_hi_q    <= rhi_q;
						out_total_q <= total_q;
						out_top_q   <= SW'(top_q);
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// start of a bound rebuild
			if (rb_start) begin
				idx_q   <= '0;
				span_q  <= high_q - low_q;
				acc_q   <= low_q;
				state_q <= ST_REB_RD;
			end

			// one bound written per symbol
			if (commit) begin
				acc_q <= acc_next;
				if (!last) begin
					idx_q   <= idx_q + IW'(1);
					state_q <= ST_REB_RD;
				end else if (gap_next != '0) begin
					gap_q   <= gap_next;
					idx_q   <= IW'(top_q) + IW'(1);
					state_q <= ST_GAP0;
				end else if (rst_pass_q) begin
					rst_pass_q <= 1'b0;
					state_q    <= ST_IDLE;
				end else begin
					state_q <= ST_OUT;
				end
			end
		end
	end

	// checks
	`AFIM_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, accept, state_q != ST_IDLE, "accepted request did no work")
	`AFIM_ASSERT(a_div_done_waited, clk, arst_n, div_rsp.done |-> state_q == ST_REB_DIV, "divider result with no waiter")
	`AFIM_ASSERT(a_gap_range, clk, arst_n, state_q == ST_GAP |-> (idx_q <= IW'(N)) && (idx_q > IW'(top_q)), "gap pass index out of range")
	`AFIM_ASSERT(a_count_write_src, clk, arst_n, c_we |-> state_q == ST_LOAD_RD || state_q == ST_SCALE || (state_q == ST_REB_RD && init_q), "unexpected count write")
endmodule

// ----- dv/adaptive_freq_interval_model_core_tb.sv -----
// testbench for adaptive_freq_interval_model_core: directed and random model traffic,
// checked against an in-bench frequency/interval predictor
// depends on afim_pkg, afim_if and the core rtl
module adaptive_freq_interval_model_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NSYM = 256;
	localparam int unsigned VW   = afim_pkg::VAL_W;
	localparam int unsigned SW   = afim_pkg::SYM_W;
	localparam int unsigned CW   = afim_pkg::CNT_W;
	localparam int unsigned MW   = afim_pkg::MODE_W;
	localparam int unsigned XW   = afim_pkg::CFG_IDX_W;

	typedef struct {
		logic [VW-1:0] range_low;
		logic [VW-1:0] range_high;
		logic [VW-1:0] total_count;
		logic [SW-1:0] top_symbol;
	} range_result_t;

	// frequency model predictor with its queue of expected results
	class interval_predictor;
		logic [VW-1:0] low_reg;
		logic [VW-1:0] high_reg;
		logic [CW-1:0] freq[NSYM];
		logic [VW-1:0] bound[NSYM+1];
		logic [VW-1:0] total;
		int unsigned   top;
		range_result_t pending_ranges[$];
		int            errors;
		int            n_results;
		int            n_requests;
		int            n_rebuilds;

		function new();
			low_reg = '0;
			high_reg = '1;
			errors = 0;
			n_results = 0;
			n_requests = 0;
			n_rebuilds = 0;
			set_uniform();
		endfunction

		function void write_reg(logic [XW-1:0] idx, logic [VW-1:0] data);
			if (idx == afim_pkg::REG_LOW)
				low_reg = data;
			else
				high_reg = data;
		endfunction

		// cumulative bounds from counts, leftover gap pushed above the top symbol
		function void rebuild();
			logic [VW-1:0] span;
			logic [VW-1:0] gap;
			logic [63:0]   part;
			span = high_reg - low_reg;
			bound[0] = low_reg;
			for (int i = 0; i < NSYM; i++) begin
				part = '0;
				if (total != 0)
					part = ({32'd0, span} * {40'd0, freq[i]}) / {32'd0, total};
				bound[i+1] = bound[i] + part[VW-1:0];
			end
			gap = high_reg - bound[NSYM];
			if (gap != 0)
				for (int i = NSYM; i > int'(top); i--)
					bound[i] = bound[i] + gap;
		endfunction

		function void set_uniform();
			foreach (freq[i])
				freq[i] = CW'(1);
			total = VW'(NSYM);
			top = NSYM - 1;
			rebuild();
		endfunction

		// scale down when over threshold, rescan top symbol, rebuild
		function void normalise();
			logic [VW-1:0] best;
			if (total > (high_reg >> 2)) begin
				total = '0;
				foreach (freq[i]) begin
					freq[i] = CW'((25'(freq[i]) + 25'd7) >> 3);
					total = total + VW'(freq[i]);
				end
			end
			best = VW'(freq[top]);
			for (int i = 0; i < NSYM; i++)
				if (VW'(freq[i]) > best) begin
					best = VW'(freq[i]);
					top = i;
				end
			rebuild();
		endfunction

		function void note_request(logic [MW-1:0] m, logic [SW-1:0] s, logic [CW-1:0] c);
			range_result_t r;
			r.range_low = '0;
			r.range_high = '0;
			n_requests++;
			case (m)
				afim_pkg::MODE_LOAD: begin
					if (s < NSYM) begin
						total = total - VW'(freq[s]) + VW'(c);
						freq[s] = c;
					end
				end
				afim_pkg::MODE_NORM: begin
					normalise();
					n_rebuilds++;
				end
				afim_pkg::MODE_INIT: begin
					set_uniform();
					n_rebuilds++;
				end
				default: begin
					if (s < NSYM) begin
						r.range_low = bound[s];
						r.range_high = bound[s+1];
					end
				end
			endcase
			r.total_count = total;
			r.top_symbol = top[SW-1:0];
			pending_ranges.push_back(r);
		endfunction

		function void check_result(range_result_t got);
			range_result_t want;
			n_results++;
			if (pending_ranges.size() == 0) begin
				$error("unexpected result: no request outstanding");
				errors++;
				return;
			end
			want = pending_ranges.pop_front();
			if (got.range_low !== want.range_low) begin
				$error("range_low expected %h actual %h", want.range_low, got.range_low);
				errors++;
			end
			if (got.range_high !== want.range_high) begin
				$error("range_high expected %h actual %h", want.range_high, got.range_high);
				errors++;
			end
			if (got.total_count !== want.total_count) begin
				$error("total_count expected %h actual %h", want.total_count,
					got.total_count);
				errors++;
			end
			if (got.top_symbol !== want.top_symbol) begin
				$error("top_symbol expected %h actual %h", want.top_symbol, got.top_symbol);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	afim_in_if  din ();
	afim_out_if dout ();
	afim_cfg_if cfg ();

	adaptive_freq_interval_model_core #(.NUM_SYMBOLS(NSYM)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din.sink),
		.dout   (dout.source),
		.cfg    (cfg.sink)
	);

	interval_predictor model = new();

	int burst_left;
	int hold_cycles;
	bit long_hold_done;
	int stall_pct;

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		#40ms;
		$display("** adaptive_freq_interval_model_core: FAILED **");
		$finish;
	end

	// result side: check accepted results, stall on a shifting pattern
	initial begin
		dout.ready = 1'b0;
		hold_cycles = 0;
		long_hold_done = 0;
		stall_pct = 0;
		forever begin
			@(posedge clk);
			if (dout.valid === 1'b1 && dout.ready === 1'b1)
				model.check_result('{dout.range_low, dout.range_high, dout.total_count,
					dout.top_symbol});
			if (!long_hold_done && model.n_results == 60) begin
				long_hold_done = 1;
				hold_cycles = 400;
			end
			if ($urandom_range(0, 199) == 0)
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 30;
					default: stall_pct = 75;
				endcase
			if (hold_cycles > 0) begin
				hold_cycles--;
				dout.ready <= 1'b0;
			end else begin
				dout.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// offer one request, keep valid up within a burst
	task automatic offer(logic [MW-1:0] m, logic [SW-1:0] s, logic [CW-1:0] c);
		int gap;
		din.valid <= 1'b1;
		din.mode <= m;
		din.symbol <= s;
		din.count <= c;
		do @(posedge clk); while (din.ready !== 1'b1);
		model.note_request(m, s, c);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				din.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain();
		din.valid <= 1'b0;
		@(posedge clk);
		while (model.pending_ranges.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(logic [XW-1:0] idx, logic [VW-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		model.write_reg(idx, data);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [CW-1:0] pick_count();
		case ($urandom_range(0, 3))
			0: return CW'($urandom_range(0, 15));
			1: return CW'($urandom());
			2: return ($urandom_range(0, 1) != 0) ? '1 : '0;
			default: return CW'($urandom_range(0, 4095));
		endcase
	endfunction

	// main sequence
	initial begin
		logic [VW-1:0] lo_set[5];
		logic [VW-1:0] hi_set[5];
		int pick;
		lo_set = '{32'h0000_0000, 32'h0000_1000, 32'hFFFF_FFF0, 32'h0000_0000, 32'hFFFF_FFFF};
		hi_set = '{32'hFFFF_FFFF, 32'h2000_0000, 32'h0000_0010, 32'h0000_0001, 32'hFFFF_FFFF};
		arst_n = 1'b0;
		din.valid = 1'b0;
		din.mode = afim_pkg::MODE_LOAD;
		din.symbol = '0;
		din.count = '0;
		cfg.valid = 1'b0;
		cfg.index = afim_pkg::REG_LOW;
		cfg.data = '0;
		burst_left = 1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		// block clears itself after reset
		do @(posedge clk); while (din.ready !== 1'b1);

		// directed: reset model, extremes, normalise, uniform rebuild
		offer(afim_pkg::MODE_QUERY, 8'd0, '0);
		offer(afim_pkg::MODE_QUERY, 8'd255, '1);
		offer(afim_pkg::MODE_LOAD, 8'd0, 24'd0);
		offer(afim_pkg::MODE_LOAD, 8'd255, 24'hFFFFFF);
		offer(afim_pkg::MODE_LOAD, 8'd7, 24'h800000);
		offer(afim_pkg::MODE_LOAD, 8'd128, 24'h7FFFFF);
		offer(afim_pkg::MODE_QUERY, 8'd7, 24'h123456);
		offer(afim_pkg::MODE_NORM, 8'd0, '0);
		offer(afim_pkg::MODE_QUERY, 8'd0, '0);
		offer(afim_pkg::MODE_QUERY, 8'd254, '0);
		offer(afim_pkg::MODE_QUERY, 8'd255, '0);
		offer(afim_pkg::MODE_NORM, 8'd3, '0);
		offer(afim_pkg::MODE_QUERY, 8'd128, '0);
		offer(afim_pkg::MODE_INIT, 8'hAA, 24'h555555);
		offer(afim_pkg::MODE_QUERY, 8'd100, '0);
		drain();

		// phases over interval settings, including high below low and minimal high
		for (int ph = 0; ph < 5; ph++) begin
			write_reg(afim_pkg::REG_LOW, lo_set[ph]);
			write_reg(afim_pkg::REG_HIGH, hi_set[ph]);
			offer(afim_pkg::MODE_INIT, SW'($urandom()), CW'($urandom()));
			offer(afim_pkg::MODE_QUERY, 8'd0, '0);
			offer(afim_pkg::MODE_QUERY, 8'd255, '0);
			if (ph == 3) begin
				// zero total: clear every count, then rebuild
				for (int s = 0; s < NSYM; s++)
					offer(afim_pkg::MODE_LOAD, SW'(s), 24'd0);
				offer(afim_pkg::MODE_NORM, 8'd0, '0);
				offer(afim_pkg::MODE_QUERY, 8'd10, '0);
				offer(afim_pkg::MODE_QUERY, 8'd255, '0);
			end
			for (int n = 0; n < 55; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 55)
					offer(afim_pkg::MODE_LOAD, SW'($urandom()), pick_count());
				else if (pick < 95)
					offer(afim_pkg::MODE_QUERY, SW'($urandom()), CW'($urandom()));
				else if (pick < 98)
					offer(afim_pkg::MODE_NORM, SW'($urandom()), CW'($urandom()));
				else
					offer(afim_pkg::MODE_INIT, SW'($urandom()), CW'($urandom()));
			end
			drain();
		end

		$display("run covered %0d requests and %0d results, %0d rebuild passes,",
			model.n_requests, model.n_results, model.n_rebuilds);
		$display("five interval settings, a zero-total model and a long output hold-off");
		if (model.errors == 0 && model.pending_ranges.size() == 0)
			$display("** adaptive_freq_interval_model_core: PASSED **");
		else
			$display("** adaptive_freq_interval_model_core: FAILED **");
		$finish;
	end
endmodule
